// File: src/prrs_pkg.sv
// shared types and command codes for the priority round-robin scheduler
package prrs_pkg;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [15:0] QUANTUM_RESET = 16'd10;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  task_id;
    logic [3:0]  priority_req;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  ran_task;
    logic [15:0] slice_length;
    logic [15:0] remaining_burst;
    logic        task_done;
    logic        idle;
    logic        add_rejected;
  } out_item_t;

endpackage

// File: src/priority_round_robin_scheduler_top.sv
// priority round-robin scheduler: linked-list queues per level over a shared task store
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   prrs_pkg::in_item_t
//   out_     output     out_valid / out_stall prrs_pkg::out_item_t
//   cfg_     input      cfg_wr_en             cfg_wr_data (time quantum)
//
// one item per cycle sustained while no result stall holds the flow; each item is
// registered in the input register, where the free-slot search, level priority
// encode and queue pop/push run, then sits in the result register, whose out_valid
// shows it until it transfers out.
// reset (synchronous, rst_n low) empties every level, frees every slot and sets
// the quantum to 10; no clearing pass is needed.
// a stalled result holds the input register, and in_stall rises behind it.
module priority_round_robin_scheduler_top #(
  parameter int LEVELS     = 10,
  parameter int TASK_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  prrs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prrs_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data
);
  import prrs_pkg::*;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LV_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // task store
  logic [7:0]        slot_task_r  [TASK_SLOTS];
  logic [15:0]       slot_burst_r [TASK_SLOTS];
  logic [SLOT_W-1:0] slot_link_r  [TASK_SLOTS];
  logic [7:0]        slot_task_nxt  [TASK_SLOTS];
  logic [15:0]       slot_burst_nxt [TASK_SLOTS];
  logic [SLOT_W-1:0] slot_link_nxt  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] has_next_r, has_next_nxt;
  logic [TASK_SLOTS-1:0] free_r, free_nxt;

  // level queues
  logic [SLOT_W-1:0] front_r [LEVELS];
  logic [SLOT_W-1:0] back_r  [LEVELS];
  logic [SLOT_W-1:0] front_nxt [LEVELS];
  logic [SLOT_W-1:0] back_nxt  [LEVELS];
  logic [LEVELS-1:0] busy_r, busy_nxt;

  logic [15:0] quantum_r;

  in_item_t  item_r;
  logic      item_v_r;
  out_item_t res_r, res_nxt;
  logic      res_v_r;
  logic      advance;

  // work logic
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              lv_found;
  logic [LV_W-1:0]   disp_lv;
  logic [LV_W-1:0]   add_lv;
  logic [SLOT_W-1:0] s;
  logic [SLOT_W-1:0] b;
  logic [15:0]       q, burst, slice, rem;

  assign advance  = item_v_r && (!res_v_r || !out_stall);
  assign in_stall = item_v_r && !advance;
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
    lv_found = 1'b0;
    disp_lv  = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (busy_r[i]) begin
        lv_found = 1'b1;
        disp_lv  = LV_W'(i);
      end
    end
  end

  // priority saturates to 1..LEVELS
  always_comb begin
    if (item_r.priority_req == 4'd0) begin
      add_lv = '0;
    end else if (32'(item_r.priority_req) > LEVELS) begin
      add_lv = LV_W'(LEVELS - 1);
    end else begin
      add_lv = LV_W'(item_r.priority_req - 4'd1);
    end
  end

  assign s     = front_r[disp_lv];
  assign b     = back_r[disp_lv];
  assign q     = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign burst = slot_burst_r[s];
  assign slice = (burst <= q) ? burst : q;
  assign rem   = burst - slice;

  always_comb begin
    slot_task_nxt  = slot_task_r;
    slot_burst_nxt = slot_burst_r;
    slot_link_nxt  = slot_link_r;
    has_next_nxt   = has_next_r;
    free_nxt       = free_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    busy_nxt       = busy_r;
    res_nxt        = '0;
    if (item_r.cmd == CMD_ADD) begin
      if (!free_found) begin
        res_nxt.add_rejected = 1'b1;
      end else begin
        free_nxt[free_slot]       = 1'b0;
        slot_task_nxt[free_slot]  = item_r.task_id;
        slot_burst_nxt[free_slot] = item_r.burst_length;
        if (busy_r[add_lv]) begin
          slot_link_nxt[free_slot] = front_r[add_lv];
          has_next_nxt[free_slot]  = 1'b1;
        end else begin
          has_next_nxt[free_slot] = 1'b0;
          back_nxt[add_lv]        = free_slot;
          busy_nxt[add_lv]        = 1'b1;
        end
        front_nxt[add_lv] = free_slot;
      end
    end else if (!lv_found) begin
      res_nxt.idle = 1'b1;
    end else begin
      res_nxt.ran_task     = slot_task_r[s];
      res_nxt.slice_length = slice;
      has_next_nxt[s]      = 1'b0;
      // pop the front
      if (has_next_r[s]) begin
        front_nxt[disp_lv] = slot_link_r[s];
      end else begin
        busy_nxt[disp_lv] = 1'b0;
      end
      if (rem == 16'd0) begin
        free_nxt[s]       = 1'b1;
        res_nxt.task_done = 1'b1;
      end else begin
        // rotate to the back of the same level
        slot_burst_nxt[s]       = rem;
        res_nxt.remaining_burst = rem;
        if (has_next_r[s]) begin
          slot_link_nxt[b] = s;
          has_next_nxt[b]  = 1'b1;
        end else begin
          front_nxt[disp_lv] = s;
          busy_nxt[disp_lv]  = 1'b1;
        end
        back_nxt[disp_lv] = s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r   <= 1'b0;
      res_v_r    <= 1'b0;
      quantum_r  <= QUANTUM_RESET;
      busy_r     <= '0;
      free_r     <= '1;
      has_next_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        item_v_r <= in_valid;
      end
      if (advance) begin
        res_v_r    <= 1'b1;
        busy_r     <= busy_nxt;
        free_r     <= free_nxt;
        has_next_r <= has_next_nxt;
      end else if (!out_stall) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_data;
    end
    if (advance) begin
      res_r          <= res_nxt;
      slot_task_r    <= slot_task_nxt;
      slot_burst_r   <= slot_burst_nxt;
      slot_link_r    <= slot_link_nxt;
      front_r        <= front_nxt;
      back_r         <= back_nxt;
    end
  end

`ifndef ASSERT_OFF
  // with every level empty no slot may be held
  a_empty_all_free: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r == '0) |-> (free_r == '1))
    else $error("slot held while every level is empty");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.idle) |->
      (out_data.slice_length == 16'd0 && !out_data.task_done && out_data.ran_task == 8'd0))
    else $error("idle result carries task data");

  a_done_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.task_done) |-> (out_data.remaining_burst == 16'd0))
    else $error("finished task reports remaining burst");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_v_r && res_v_r && out_stall))
    else $error("input stalled without a blocked result");

  a_one_per_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(res_r)))
    else $error("held result lost or changed");
`endif

endmodule

// File: verif/testbench.sv
// self-checking testbench for the priority round-robin scheduler with random handshake idling
module testbench;
  import prrs_pkg::*;

  localparam int LEVELS      = 10;
  localparam int TASK_SLOTS  = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 290;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  priority_round_robin_scheduler_top #(
    .LEVELS     (LEVELS),
    .TASK_SLOTS (TASK_SLOTS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // scheduler mirror
  logic [7:0]  slot_owner  [TASK_SLOTS];
  logic [15:0] slot_left   [TASK_SLOTS];
  int          slot_next   [TASK_SLOTS];
  bit          slot_linked [TASK_SLOTS];
  bit          slot_free   [TASK_SLOTS];
  int          lvl_front   [LEVELS];
  int          lvl_back    [LEVELS];
  bit          lvl_busy    [LEVELS];
  logic [15:0] quantum;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  int  errors = 0;
  int  n_adds = 0, n_rejected = 0, n_dispatches = 0, n_idle = 0;
  int  n_finished = 0, n_requeued = 0, n_settings = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t   r;
    int          s;
    int          lv;
    int          q;
    logic [15:0] slice;
    logic [15:0] rest;
    r = '0;
    if (it.cmd == CMD_ADD) begin
      n_adds++;
      s = -1;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) if (slot_free[i]) s = i;
      if (s < 0) begin
        r.add_rejected = 1'b1;
        n_rejected++;
      end else begin
        // out-of-range priorities saturate into the valid levels
        if (it.priority_req == 4'd0) lv = 0;
        else if (int'(it.priority_req) > LEVELS) lv = LEVELS - 1;
        else lv = int'(it.priority_req) - 1;
        slot_free[s]  = 1'b0;
        slot_owner[s] = it.task_id;
        slot_left[s]  = it.burst_length;
        if (lvl_busy[lv]) begin
          slot_next[s]   = lvl_front[lv];
          slot_linked[s] = 1'b1;
        end else begin
          slot_linked[s] = 1'b0;
          lvl_back[lv]   = s;
          lvl_busy[lv]   = 1'b1;
        end
        lvl_front[lv] = s;
      end
    end else begin
      n_dispatches++;
      lv = -1;
      for (int i = 0; i < LEVELS; i++) if (lvl_busy[i]) lv = i;
      if (lv < 0) begin
        r.idle = 1'b1;
        n_idle++;
      end else begin
        s     = lvl_front[lv];
        q     = (quantum == 16'd0) ? 1 : int'(quantum);
        slice = (int'(slot_left[s]) <= q) ? slot_left[s] : 16'(q);
        rest  = slot_left[s] - slice;
        if (slot_linked[s]) lvl_front[lv] = slot_next[s];
        else lvl_busy[lv] = 1'b0;
        r.ran_task     = slot_owner[s];
        r.slice_length = slice;
        if (rest == 16'd0) begin
          slot_free[s]   = 1'b1;
          slot_linked[s] = 1'b0;
          r.task_done    = 1'b1;
          n_finished++;
        end else begin
          // rotate to the back of the same level
          r.remaining_burst = rest;
          slot_left[s]      = rest;
          slot_linked[s]    = 1'b0;
          if (lvl_busy[lv]) begin
            slot_next[lvl_back[lv]]   = s;
            slot_linked[lvl_back[lv]] = 1'b1;
          end else begin
            lvl_front[lv] = s;
            lvl_busy[lv]  = 1'b1;
          end
          lvl_back[lv] = s;
          n_requeued++;
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t task_item(logic c, int id, int pri, int burst);
    in_item_t it;
    it.cmd          = c;
    it.task_id      = 8'(id);
    it.priority_req = 4'(pri);
    it.burst_length = 16'(burst);
    return it;
  endfunction

  function automatic in_item_t random_item(int add_pct);
    int r;
    int pri;
    int burst;
    if ($urandom_range(0, 99) >= add_pct)
      return task_item(CMD_DISPATCH, $urandom_range(0, 255), $urandom_range(0, 15),
                       $urandom_range(0, 65535));
    pri = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 15) : $urandom_range(1, LEVELS);
    r = $urandom_range(0, 99);
    if (r < 3) burst = 0;
    else if (r < 5) burst = 65535;
    else if (r < 9) burst = $urandom_range(0, 65535);
    else burst = $urandom_range(1, 40);
    return task_item(CMD_ADD, $urandom_range(0, 255), pri, burst);
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $error("%s expected %0d got %0d", name, want, got);
    end
  endtask

  // driver: presents queued items, random gaps between transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected_results.push_back(schedule_step(in_data));
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end
    end
  end

  // monitor: random stall bursts, compares each result transfer
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $error("result with nothing expected, ran_task %0d", out_data.ran_task);
        end else begin
          want = expected_results.pop_front();
          check_field("ran_task", 16'(want.ran_task), 16'(out_data.ran_task));
          check_field("slice_length", want.slice_length, out_data.slice_length);
          check_field("remaining_burst", want.remaining_burst, out_data.remaining_burst);
          check_field("task_done", 16'(want.task_done), 16'(out_data.task_done));
          check_field("idle", 16'(want.idle), 16'(out_data.idle));
          check_field("add_rejected", 16'(want.add_rejected), 16'(out_data.add_rejected));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sender holds off until every result is back and the pipeline is empty
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_quantum(logic [15:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    quantum = value;
    n_settings++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int quanta [6];
    int add_pct;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_owner[i]  = '0;
      slot_left[i]   = '0;
      slot_next[i]   = 0;
      slot_linked[i] = 1'b0;
      slot_free[i]   = 1'b1;
    end
    for (int i = 0; i < LEVELS; i++) begin
      lvl_front[i] = 0;
      lvl_back[i]  = 0;
      lvl_busy[i]  = 1'b0;
    end
    quantum = QUANTUM_RESET;
    n_settings = 1;
    add_pct = 50;
    quanta = '{3, 1, 65535, 0, 0, 10};
    quanta[4] = $urandom_range(2, 50);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dispatch, extreme fields, saturation, zero burst, full store
    pending_items.push_back(task_item(CMD_DISPATCH, 0, 0, 0));
    pending_items.push_back(task_item(CMD_ADD, 255, 10, 65535));
    pending_items.push_back(task_item(CMD_ADD, 0, 0, 0));
    pending_items.push_back(task_item(CMD_ADD, 8'h5a, 15, 25));
    pending_items.push_back(task_item(CMD_ADD, 8'ha5, 5, 10));
    pending_items.push_back(task_item(CMD_DISPATCH, 255, 15, 65535));
    for (int k = 0; k < 12; k++)
      pending_items.push_back(task_item(CMD_ADD, 8'h10 + k, k, k + 1));
    pending_items.push_back(task_item(CMD_ADD, 8'h77, 7, 7));
    for (int k = 0; k < 6; k++)
      pending_items.push_back(task_item(CMD_DISPATCH, 0, 0, 0));
    drain();

    foreach (quanta[p]) begin
      set_quantum(16'(quanta[p]));
      if (p == 5) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // vary the add mix so the store fills up and drains again
        if (i % 40 == 0) add_pct = 25 * $urandom_range(1, 3);
        pending_items.push_back(random_item(add_pct));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d adds (%0d refused on a full store) and %0d dispatches",
             n_adds, n_rejected, n_dispatches);
    $display("dispatches: %0d on empty levels, %0d finished, %0d rotated; %0d quantum values",
             n_idle, n_finished, n_requeued, n_settings);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
